// ----- rtl/kit_pkg.sv -----
// ----------------------------------------------------------------------------
// kit_pkg: shared types and constants of the keyword and integer tokenizer
// Result record, push bundle, queue status, token kinds, character codes and
// the keyword spelling table.
// ----------------------------------------------------------------------------
package kit_pkg;

   // fixed widths of the result fields
   localparam int KIND_BITS      = 4;
   localparam int INT_VALUE_BITS = 32;
   localparam int POS_OUT_BITS   = 16;

   // token kinds
   localparam logic [KIND_BITS-1:0] KIND_COMMA   = 4'd0;
   localparam logic [KIND_BITS-1:0] KIND_LPAREN  = 4'd1;
   localparam logic [KIND_BITS-1:0] KIND_RPAREN  = 4'd2;
   localparam logic [KIND_BITS-1:0] KIND_INTEGER = 4'd3;
   localparam logic [KIND_BITS-1:0] KIND_CLOSED  = 4'd4;
   localparam logic [KIND_BITS-1:0] KIND_SEARCH  = 4'd5;
   localparam logic [KIND_BITS-1:0] KIND_OPENED  = 4'd6;
   localparam logic [KIND_BITS-1:0] KIND_PATH    = 4'd7;
   localparam logic [KIND_BITS-1:0] KIND_ERROR   = 4'd8;

   // character codes
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_RETURN  = 8'h0D;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_LPAREN  = 8'h28;
   localparam logic [7:0] CH_RPAREN  = 8'h29;
   localparam logic [7:0] CH_COMMA   = 8'h2C;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CASE_BIT   = 8'h20;

   // scanner mode
   typedef enum logic [1:0] {
      MODE_START,
      MODE_INT,
      MODE_WORD
   } mode_type;

   // keywords, spelled left aligned in six bytes
   localparam int KW_COUNT = 4;
   localparam logic [47:0] KW_TEXT [KW_COUNT] = '{
      "closed", "search", "opened", {"path", 16'h0000}
   };
   localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd6, 3'd6, 3'd6, 3'd4};

   // output queue
   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
   localparam int LEVEL_BITS  = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [KIND_BITS-1:0]      token_kind;
      logic [INT_VALUE_BITS-1:0] int_value;
      logic                      int_overflow;
      logic [POS_OUT_BITS-1:0]   token_line;
      logic [POS_OUT_BITS-1:0]   start_column;
      logic                      last_result;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

   typedef struct packed {
      logic                  room;
      logic [LEVEL_BITS-1:0] level;
   } queue_status_type;

   // lowercase letter at position pos of keyword k
   function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] pos);
      logic [47:0] text;
      logic [2:0]  slot;
      text = KW_TEXT[k];
      slot = 3'd5 - pos;
      return text[{slot, 3'b000} +: 8];
   endfunction

endpackage

// ----- rtl/kit_scan.sv -----
// ----------------------------------------------------------------------------
// kit_scan: input register and scanner state
// Registers one character beat, then, once the queue has room for a pair, advances line/column,
// the scanner mode and the integer accumulator, producing up to two results.
// ----------------------------------------------------------------------------
module kit_scan #(
   parameter int VALUE_BITS    = 32,
   parameter int POSITION_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [7:0]                req_char_code,
   input  logic                      req_end_of_input,
   input  kit_pkg::queue_status_type q_status,
   output kit_pkg::push_type         push
);
   import kit_pkg::*;

   localparam int ACC_WIDE  = VALUE_BITS + 4;
   localparam int VALUE_EXT = (VALUE_BITS > INT_VALUE_BITS) ? VALUE_BITS : INT_VALUE_BITS;
   localparam int POS_EXT   = (POSITION_BITS > POS_OUT_BITS) ? POSITION_BITS : POS_OUT_BITS;
   localparam logic [VALUE_BITS-1:0]    VALUE_MAX = '1;
   localparam logic [POSITION_BITS-1:0] POS_MAX   = '1;
   localparam logic [POSITION_BITS-1:0] POS_ONE   = POSITION_BITS'(1);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] char_ff;
   logic       end_ff;
   logic       advance;

   // scanner state
   mode_type                 mode_ff, mode_in;
   logic [1:0]               kw_ff, kw_in;
   logic [2:0]               match_ff, match_in;
   logic [VALUE_BITS-1:0]    acc_ff, acc_in;
   logic                     ovf_ff, ovf_in;
   logic [POSITION_BITS-1:0] line_ff, line_in;
   logic [POSITION_BITS-1:0] col_ff, col_in;
   logic [POSITION_BITS-1:0] tsl_ff, tsl_in;
   logic [POSITION_BITS-1:0] tsc_ff, tsc_in;
   logic                     err_ff, err_in;

   // working signals
   logic [POSITION_BITS-1:0] line_u, col_u;
   logic [ACC_WIDE-1:0]      acc_x10;
   logic [7:0]               lower;
   logic                     is_space, is_digit;
   logic                     kw_hit;
   logic [1:0]               kw_idx;
   logic                     do_start;
   logic                     lead_v, start_v;
   result_type               lead_r, start_r;

   function automatic result_type make_result(
      input logic [KIND_BITS-1:0]     kind,
      input logic [VALUE_BITS-1:0]    value,
      input logic                     ovf,
      input logic [POSITION_BITS-1:0] line,
      input logic [POSITION_BITS-1:0] col
   );
      result_type             r;
      logic [VALUE_EXT-1:0]   value_w;
      logic [POS_EXT-1:0]     line_w;
      logic [POS_EXT-1:0]     col_w;
      value_w        = VALUE_EXT'(value);
      line_w         = POS_EXT'(line);
      col_w          = POS_EXT'(col);
      r.token_kind   = kind;
      r.int_value    = value_w[INT_VALUE_BITS-1:0];
      r.int_overflow = ovf;
      r.token_line   = line_w[POS_OUT_BITS-1:0];
      r.start_column = col_w[POS_OUT_BITS-1:0];
      r.last_result  = 1'b0;
      return r;
   endfunction

   // handshake: the input register frees up when its beat is processed
   assign advance     = in_valid_ff && q_status.room;
   assign req_ready   = !in_valid_ff || advance;
   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         char_ff <= req_char_code;
         end_ff  <= req_end_of_input;
      end
   end

   // character classes
   assign lower    = char_ff | CASE_BIT;
   assign is_space = char_ff inside {CH_SPACE, CH_NEWLINE, CH_RETURN, CH_TAB};
   assign is_digit = char_ff inside {[CH_ZERO:CH_NINE]};

   // first letter of a keyword
   always_comb begin
      kw_hit = 1'b0;
      kw_idx = 2'd0;
      for (int j = 0; j < KW_COUNT; j++) begin
         if (lower == kw_char(2'(j), 3'd0)) begin
            kw_hit = 1'b1;
            kw_idx = 2'(j);
         end
      end
   end

   // acc * 10 + digit, shift-add
   assign acc_x10 = (ACC_WIDE'(acc_ff) << 3) + (ACC_WIDE'(acc_ff) << 1)
                    + ACC_WIDE'(char_ff[3:0]);

   // scan step
   always_comb begin
      mode_in  = mode_ff;
      kw_in    = kw_ff;
      match_in = match_ff;
      acc_in   = acc_ff;
      ovf_in   = ovf_ff;
      line_in  = line_ff;
      col_in   = col_ff;
      tsl_in   = tsl_ff;
      tsc_in   = tsc_ff;
      err_in   = err_ff;
      line_u   = line_ff;
      col_u    = col_ff;
      do_start = 1'b0;
      lead_v   = 1'b0;
      start_v  = 1'b0;
      lead_r   = '0;
      start_r  = '0;

      if (advance) begin
         if (err_ff) begin
            // sticky error: repeat it with the latched position
            lead_v = 1'b1;
            lead_r = make_result(KIND_ERROR, '0, 1'b0, tsl_ff, tsc_ff);
         end else if (end_ff) begin
            // flush a pending token
            mode_in = MODE_START;
            case (mode_ff)
               MODE_INT: begin
                  lead_v = 1'b1;
                  lead_r = make_result(KIND_INTEGER, acc_ff, ovf_ff, tsl_ff, tsc_ff);
               end
               MODE_WORD: begin
                  lead_v = 1'b1;
                  if (match_ff == KW_LEN[kw_ff]) begin
                     lead_r = make_result(KIND_CLOSED + KIND_BITS'(kw_ff), '0, 1'b0,
                                          tsl_ff, tsc_ff);
                  end else begin
                     lead_r = make_result(KIND_ERROR, '0, 1'b0, tsl_ff, tsc_ff);
                     err_in = 1'b1;
                  end
               end
               default: ;
            endcase
         end else begin
            // position counters, saturating
            if (char_ff == CH_NEWLINE) begin
               if (line_ff < POS_MAX) begin
                  line_u = line_ff + POS_ONE;
               end
               col_u = '0;
            end else if (col_ff < POS_MAX) begin
               col_u = col_ff + POS_ONE;
            end
            line_in = line_u;
            col_in  = col_u;

            case (mode_ff)
               MODE_INT: begin
                  if (is_digit) begin
                     if (acc_x10[ACC_WIDE-1:VALUE_BITS] != '0) begin
                        acc_in = VALUE_MAX;
                        ovf_in = 1'b1;
                     end else begin
                        acc_in = acc_x10[VALUE_BITS-1:0];
                     end
                  end else begin
                     lead_v   = 1'b1;
                     lead_r   = make_result(KIND_INTEGER, acc_ff, ovf_ff, tsl_ff, tsc_ff);
                     do_start = 1'b1;
                  end
               end
               MODE_WORD: begin
                  if (match_ff < KW_LEN[kw_ff]) begin
                     if (lower == kw_char(kw_ff, match_ff)) begin
                        match_in = match_ff + 3'd1;
                     end else begin
                        lead_v = 1'b1;
                        lead_r = make_result(KIND_ERROR, '0, 1'b0, tsl_ff, tsc_ff);
                        err_in = 1'b1;
                     end
                  end else if (is_space) begin
                     lead_v   = 1'b1;
                     lead_r   = make_result(KIND_CLOSED + KIND_BITS'(kw_ff), '0, 1'b0,
                                            tsl_ff, tsc_ff);
                     do_start = 1'b1;
                  end else begin
                     lead_v = 1'b1;
                     lead_r = make_result(KIND_ERROR, '0, 1'b0, tsl_ff, tsc_ff);
                     err_in = 1'b1;
                  end
               end
               default: begin
                  do_start = 1'b1;
               end
            endcase

            // start state pass: a new token begins here
            if (do_start) begin
               mode_in = MODE_START;
               tsl_in  = line_u;
               tsc_in  = col_u;
               acc_in  = '0;
               ovf_in  = 1'b0;
               if (is_space) begin
                  // skipped
               end else if (char_ff == CH_COMMA) begin
                  start_v = 1'b1;
                  start_r = make_result(KIND_COMMA, '0, 1'b0, line_u, col_u);
               end else if (char_ff == CH_LPAREN) begin
                  start_v = 1'b1;
                  start_r = make_result(KIND_LPAREN, '0, 1'b0, line_u, col_u);
               end else if (char_ff == CH_RPAREN) begin
                  start_v = 1'b1;
                  start_r = make_result(KIND_RPAREN, '0, 1'b0, line_u, col_u);
               end else if (is_digit) begin
                  mode_in = MODE_INT;
                  acc_in  = VALUE_BITS'(char_ff[3:0]);
               end else if (kw_hit) begin
                  mode_in  = MODE_WORD;
                  kw_in    = kw_idx;
                  match_in = 3'd1;
               end else begin
                  start_v = 1'b1;
                  start_r = make_result(KIND_ERROR, '0, 1'b0, line_u, col_u);
                  err_in  = 1'b1;
               end
            end
         end
      end
   end

   // pack results into the push bundle, marking the last one
   always_comb begin
      push.count              = {1'b0, lead_v} + {1'b0, start_v};
      push.first              = lead_v ? lead_r : start_r;
      push.first.last_result  = !(lead_v && start_v);
      push.second             = start_r;
      push.second.last_result = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_START;
         kw_ff    <= 2'd0;
         match_ff <= 3'd0;
         acc_ff   <= '0;
         ovf_ff   <= 1'b0;
         line_ff  <= POS_ONE;
         col_ff   <= POS_ONE;
         tsl_ff   <= POS_ONE;
         tsc_ff   <= POS_ONE;
         err_ff   <= 1'b0;
      end else begin
         mode_ff  <= mode_in;
         kw_ff    <= kw_in;
         match_ff <= match_in;
         acc_ff   <= acc_in;
         ovf_ff   <= ovf_in;
         line_ff  <= line_in;
         col_ff   <= col_in;
         tsl_ff   <= tsl_in;
         tsc_ff   <= tsc_in;
         err_ff   <= err_in;
      end
   end

endmodule

// ----- rtl/kit_queue.sv -----
// ----------------------------------------------------------------------------
// kit_queue: result queue
// Small register queue taking up to two results per cycle and handing out
// one result beat per cycle while rsp_ready is high.
// ----------------------------------------------------------------------------
module kit_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  kit_pkg::push_type         push,
   input  logic                      rsp_ready,
   output logic                      rsp_valid,
   output kit_pkg::result_type       head,
   output kit_pkg::queue_status_type q_status
);
   import kit_pkg::*;

   result_type            mem_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_BITS-1:0]   wr_next;
   logic [LEVEL_BITS-1:0] level_ff, level_in;
   logic                  pop;

   assign rsp_valid = level_ff != '0;
   assign head      = mem_ff[rd_ptr_ff];
   assign pop       = rsp_valid && rsp_ready;

   // room for a full pair of results
   assign q_status.room  = level_ff <= LEVEL_BITS'(QUEUE_DEPTH - 2);
   assign q_status.level = level_ff;

   assign wr_next   = wr_ptr_ff + PTR_BITS'(1);
   assign wr_ptr_in = wr_ptr_ff + PTR_BITS'(push.count);
   assign rd_ptr_in = rd_ptr_ff + PTR_BITS'(pop);
   assign level_in  = level_ff + LEVEL_BITS'(push.count) - LEVEL_BITS'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_next] <= push.second;
      end
   end

endmodule

// ----- rtl/keyword_integer_tokenizer.sv -----
// ----------------------------------------------------------------------------
// keyword_integer_tokenizer: character stream tokenizer
// Tracks line and column, emits punctuation, saturating integer and keyword
// tokens, and latches the first error until reset.
// ----------------------------------------------------------------------------
// Path: a character beat is held in the input register, then its results are written to the queue that feeds the port.
// Throughput: one character per cycle; a character that gives two results takes two
// result beats on the single result port; input holds off while the 4-entry queue has < 2 free.
// Reset (synchronous, active high) empties the queue, returns the scanner to its
// start state and sets line, column and token start to 1.
module keyword_integer_tokenizer #(
   parameter int VALUE_BITS    = 32,
   parameter int POSITION_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [7:0]                          req_char_code,
   input  logic                                req_end_of_input,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [kit_pkg::KIND_BITS-1:0]       rsp_token_kind,
   output logic [kit_pkg::INT_VALUE_BITS-1:0]  rsp_int_value,
   output logic                                rsp_int_overflow,
   output logic [kit_pkg::POS_OUT_BITS-1:0]    rsp_token_line,
   output logic [kit_pkg::POS_OUT_BITS-1:0]    rsp_start_column,
   output logic                                rsp_last_result
);
   import kit_pkg::*;

   push_type         push;
   queue_status_type q_status;
   result_type       head;

   kit_scan #(
      .VALUE_BITS    (VALUE_BITS),
      .POSITION_BITS (POSITION_BITS)
   ) u_scan (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_char_code    (req_char_code),
      .req_end_of_input (req_end_of_input),
      .q_status         (q_status),
      .push             (push)
   );

   kit_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .head      (head),
      .q_status  (q_status)
   );

   // result beat fields
   assign rsp_token_kind   = head.token_kind;
   assign rsp_int_value    = head.int_value;
   assign rsp_int_overflow = head.int_overflow;
   assign rsp_token_line   = head.token_line;
   assign rsp_start_column = head.start_column;
   assign rsp_last_result  = head.last_result;

   // queue never overfills
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      q_status.level <= LEVEL_BITS'(QUEUE_DEPTH))
      else $error("result queue over capacity");

   // results are pushed only when a pair fits
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> q_status.room)
      else $error("push without room");

   // of a pair, only the second is marked last
   a_pair_last: assert property (@(posedge clock) disable iff (reset)
      (push.count == 2'd2) |-> (!push.first.last_result && push.second.last_result))
      else $error("bad last marking on result pair");

   // a pair always opens with an integer or keyword token
   a_pair_lead: assert property (@(posedge clock) disable iff (reset)
      (push.count == 2'd2) |-> (push.first.token_kind == KIND_INTEGER ||
                                push.first.token_kind == KIND_CLOSED ||
                                push.first.token_kind == KIND_SEARCH ||
                                push.first.token_kind == KIND_OPENED ||
                                push.first.token_kind == KIND_PATH))
      else $error("result pair with unexpected first kind");

endmodule
